@@ sv/jtc_pkg.sv @@
// Package for the JSON token classifier: token codes, scan modes, result bundle and byte classes.
package jtc_pkg;

  // Largest token length reported; longer tokens saturate here.
  localparam int MAX_TOKEN_BYTES = 255;
  localparam int LEN_CAP_INT     = (MAX_TOKEN_BYTES < 255) ? MAX_TOKEN_BYTES : 255;
  localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

  // Results one text byte can cause, and the default depth of the result queue.
  localparam int MAX_RES     = 4;
  localparam int QUEUE_DEPTH = 4;

  // Request codes on the input channel.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  typedef enum logic [3:0] {
    TOK_LBRACE   = 4'd0,
    TOK_RBRACE   = 4'd1,
    TOK_LBRACKET = 4'd2,
    TOK_RBRACKET = 4'd3,
    TOK_COMMA    = 4'd4,
    TOK_COLON    = 4'd5,
    TOK_STRING   = 4'd6,
    TOK_LITERAL  = 4'd7,
    TOK_INTEGER  = 4'd8,
    TOK_FLOAT    = 4'd9,
    TOK_INVALID  = 4'd10
  } tok_t;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_STRING  = 3'd1,
    M_LITERAL = 3'd2,
    M_INT     = 3'd3,
    M_DOT     = 3'd4,
    M_FRAC    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    LIT_TRUE  = 2'd0,
    LIT_FALSE = 2'd1,
    LIT_NULL  = 2'd2,
    LIT_NULL2 = 2'd3
  } lit_t;

  // Character codes.
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6E;

  typedef struct packed {
    tok_t       tok_code;
    logic [7:0] token_length;
  } res_t;

  // All results caused by one accepted input transaction.
  typedef struct packed {
    logic [2:0]              count;
    res_t [MAX_RES-1:0]      items;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic string_ok(input logic [7:0] b);
    logic ok;
    ok = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) || is_digit(b);
    ok = ok || ((b >= 8'h80) && (b <= 8'hC3));
    ok = ok || (b == CH_COMMA) || (b == CH_COLON) || (b == 8'h5F) || (b == CH_LBRACE) ||
         (b == CH_RBRACE) || (b == CH_LBRACKET) || (b == CH_RBRACKET) || (b == 8'h2D) ||
         (b == CH_DOT) || (b == 8'h21) || (b == CH_SPACE);
    return ok;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] x);
    return (x < LEN_CAP) ? x + 8'd1 : x;
  endfunction

  function automatic logic [2:0] lit_len(input lit_t k);
    return (k == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  // Expected letter at a position of a literal word.
  function automatic logic [7:0] lit_char(input lit_t k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      LIT_TRUE: begin
        case (pos)
          3'd0: c = 8'h74;
          3'd1: c = 8'h72;
          3'd2: c = 8'h75;
          3'd3: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (pos)
          3'd0: c = 8'h66;
          3'd1: c = 8'h61;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h73;
          3'd4: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0: c = 8'h6E;
          3'd1: c = 8'h75;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

@@ sv/jtc_in_if.sv @@
// Input channel interface: request type and text byte with valid and ready.
interface jtc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

@@ sv/jtc_out_if.sv @@
// Output channel interface: token code, length and last-of-run flag with valid and ready.
interface jtc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] tok_code;
  logic [7:0] token_length;
  logic       last_of_run;

  modport source (output valid, output tok_code, output token_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input tok_code, input token_length, input last_of_run,
                  output ready);
endinterface

@@ sv/json_token_classifier.sv @@
// Top level of the JSON token classifier: front end, result queue and back end.
//
//   Channel    Modport  Payload                                   Transaction
//   text_in    sink     req_type(1), in_byte(8)                   one text byte or end of input
//   token_out  source   tok_code(4), token_length(8),             one finished token
//                       last_of_run(1)
//
// A text byte is taken every cycle while the result queue has room. The queue registers its
// bundle at the edge that accepts the byte, and the back end then loads it into its own
// register before the first result is offered; after that one result per cycle is handed
// out while the output is taken. Reset is synchronous and returns the scanner to idle with
// the queue empty.
// The input stalls only when the queue of QUEUE_DEPTH bundles is full; the output stalls
// freely, holding its transaction until taken.
module json_token_classifier #(
  parameter int QUEUE_DEPTH = jtc_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  jtc_in_if.sink    text_in,
  jtc_out_if.source token_out
);

  // Bundles flow from the scanner into the queue whenever a byte causes any result.
  logic             queue_full;
  logic             bundle_push;
  jtc_pkg::bundle_t bundle;

  // The back end drains the queue one bundle at a time.
  logic             q_valid;
  logic             q_pop;
  jtc_pkg::bundle_t q_data;

  // The front end decides every result of a byte within the cycle it is accepted.
  jtc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_in     (text_in),
    .queue_full  (queue_full),
    .bundle_push (bundle_push),
    .bundle      (bundle)
  );

  // The queue absorbs bursts so that the scanner need not wait for the output side.
  jtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (bundle_push),
    .push_data (bundle),
    .pop       (q_pop),
    .full      (queue_full),
    .not_empty (q_valid),
    .head_data (q_data)
  );

  // The back end serialises each bundle and flags its final result.
  jtc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop),
    .token_out (token_out)
  );

endmodule

@@ sv/jtc_front.sv @@
// Front end: scans one byte per cycle while the queue has room and builds the bundle of results it causes.
module jtc_front (
  input  logic              clk,
  input  logic              rst,
  jtc_in_if.sink            text_in,
  input  logic              queue_full,
  output logic              bundle_push,
  output jtc_pkg::bundle_t  bundle
);

  jtc_pkg::mode_t mode, mode_next;
  jtc_pkg::lit_t  lit_kind, lit_kind_next;
  logic [7:0]     run_len, run_len_next;
  logic [7:0]     lz_cnt, lz_cnt_next;
  logic [7:0]     id_cnt, id_cnt_next;

  logic           in_fire;
  logic           taken;
  logic [2:0]     n;
  logic [7:0]     b;
  jtc_pkg::res_t [jtc_pkg::MAX_RES-1:0] items;

  assign text_in.ready = !queue_full;
  assign in_fire       = text_in.valid && text_in.ready;
  assign b             = text_in.in_byte;

  always_comb begin
    mode_next     = mode;
    lit_kind_next = lit_kind;
    run_len_next  = run_len;
    lz_cnt_next   = lz_cnt;
    id_cnt_next   = id_cnt;
    items         = '0;
    n             = 3'd0;
    taken         = 1'b0;

    if (text_in.req_type == jtc_pkg::REQ_END) begin
      case (mode)
        jtc_pkg::M_STRING, jtc_pkg::M_LITERAL: begin
          items[n[1:0]] = '{jtc_pkg::TOK_INVALID, run_len};
          n = n + 3'd1;
        end
        jtc_pkg::M_INT, jtc_pkg::M_DOT, jtc_pkg::M_FRAC: begin
          if (mode == jtc_pkg::M_FRAC) begin
            items[n[1:0]] = '{jtc_pkg::TOK_FLOAT, run_len};
            n = n + 3'd1;
          end else begin
            if (lz_cnt != 8'd0) begin
              items[n[1:0]] = '{jtc_pkg::TOK_INVALID, lz_cnt};
              n = n + 3'd1;
            end
            if (id_cnt != 8'd0) begin
              items[n[1:0]] = '{jtc_pkg::TOK_INTEGER, id_cnt};
              n = n + 3'd1;
            end
            if (mode == jtc_pkg::M_DOT) begin
              items[n[1:0]] = '{jtc_pkg::TOK_INVALID, 8'd1};
              n = n + 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
      mode_next    = jtc_pkg::M_IDLE;
      run_len_next = 8'd0;
      lz_cnt_next  = 8'd0;
      id_cnt_next  = 8'd0;
    end else begin
      // Let the pending token try to take the byte.
      case (mode)
        jtc_pkg::M_STRING: begin
          if (b == jtc_pkg::CH_QUOTE) begin
            items[n[1:0]] = '{jtc_pkg::TOK_STRING, jtc_pkg::sat_inc(run_len)};
            n = n + 3'd1;
            mode_next    = jtc_pkg::M_IDLE;
            run_len_next = 8'd0;
            lz_cnt_next  = 8'd0;
            id_cnt_next  = 8'd0;
            taken = 1'b1;
          end else if (jtc_pkg::string_ok(b)) begin
            run_len_next = jtc_pkg::sat_inc(run_len);
            taken = 1'b1;
          end else begin
            items[n[1:0]] = '{jtc_pkg::TOK_INVALID, run_len};
            n = n + 3'd1;
          end
        end
        jtc_pkg::M_LITERAL: begin
          if ((run_len < {5'd0, jtc_pkg::lit_len(lit_kind)}) &&
              (jtc_pkg::lit_char(lit_kind, run_len[2:0]) == b)) begin
            run_len_next = run_len + 8'd1;
            taken = 1'b1;
            if (run_len_next >= {5'd0, jtc_pkg::lit_len(lit_kind)}) begin
              items[n[1:0]] = '{jtc_pkg::TOK_LITERAL, run_len_next};
              n = n + 3'd1;
              mode_next    = jtc_pkg::M_IDLE;
              run_len_next = 8'd0;
              lz_cnt_next  = 8'd0;
              id_cnt_next  = 8'd0;
            end
          end else begin
            items[n[1:0]] = '{jtc_pkg::TOK_INVALID, run_len};
            n = n + 3'd1;
          end
        end
        jtc_pkg::M_INT, jtc_pkg::M_DOT: begin
          if (jtc_pkg::is_digit(b)) begin
            if (mode == jtc_pkg::M_INT) begin
              if ((b == jtc_pkg::CH_ZERO) && (id_cnt == 8'd0)) begin
                lz_cnt_next = jtc_pkg::sat_inc(lz_cnt);
              end else begin
                id_cnt_next = jtc_pkg::sat_inc(id_cnt);
              end
            end else begin
              mode_next = jtc_pkg::M_FRAC;
            end
            run_len_next = jtc_pkg::sat_inc(run_len);
            taken = 1'b1;
          end else if ((mode == jtc_pkg::M_INT) && (b == jtc_pkg::CH_DOT)) begin
            mode_next    = jtc_pkg::M_DOT;
            run_len_next = jtc_pkg::sat_inc(run_len);
            taken = 1'b1;
          end else begin
            if (lz_cnt != 8'd0) begin
              items[n[1:0]] = '{jtc_pkg::TOK_INVALID, lz_cnt};
              n = n + 3'd1;
            end
            if (id_cnt != 8'd0) begin
              items[n[1:0]] = '{jtc_pkg::TOK_INTEGER, id_cnt};
              n = n + 3'd1;
            end
            if (mode == jtc_pkg::M_DOT) begin
              items[n[1:0]] = '{jtc_pkg::TOK_INVALID, 8'd1};
              n = n + 3'd1;
            end
          end
        end
        jtc_pkg::M_FRAC: begin
          if (jtc_pkg::is_digit(b)) begin
            run_len_next = jtc_pkg::sat_inc(run_len);
            taken = 1'b1;
          end else begin
            items[n[1:0]] = '{jtc_pkg::TOK_FLOAT, run_len};
            n = n + 3'd1;
          end
        end
        default: begin
        end
      endcase

      // The byte opens a new token, or is looked at again after the old one ended.
      if (!taken) begin
        mode_next    = jtc_pkg::M_IDLE;
        run_len_next = 8'd0;
        lz_cnt_next  = 8'd0;
        id_cnt_next  = 8'd0;
        case (b)
          jtc_pkg::CH_LBRACE: begin
            items[n[1:0]] = '{jtc_pkg::TOK_LBRACE, 8'd1};
            n = n + 3'd1;
          end
          jtc_pkg::CH_RBRACE: begin
            items[n[1:0]] = '{jtc_pkg::TOK_RBRACE, 8'd1};
            n = n + 3'd1;
          end
          jtc_pkg::CH_LBRACKET: begin
            items[n[1:0]] = '{jtc_pkg::TOK_LBRACKET, 8'd1};
            n = n + 3'd1;
          end
          jtc_pkg::CH_RBRACKET: begin
            items[n[1:0]] = '{jtc_pkg::TOK_RBRACKET, 8'd1};
            n = n + 3'd1;
          end
          jtc_pkg::CH_COMMA: begin
            items[n[1:0]] = '{jtc_pkg::TOK_COMMA, 8'd1};
            n = n + 3'd1;
          end
          jtc_pkg::CH_COLON: begin
            items[n[1:0]] = '{jtc_pkg::TOK_COLON, 8'd1};
            n = n + 3'd1;
          end
          jtc_pkg::CH_QUOTE: begin
            mode_next    = jtc_pkg::M_STRING;
            run_len_next = 8'd1;
          end
          jtc_pkg::CH_T: begin
            mode_next     = jtc_pkg::M_LITERAL;
            lit_kind_next = jtc_pkg::LIT_TRUE;
            run_len_next  = 8'd1;
          end
          jtc_pkg::CH_F: begin
            mode_next     = jtc_pkg::M_LITERAL;
            lit_kind_next = jtc_pkg::LIT_FALSE;
            run_len_next  = 8'd1;
          end
          jtc_pkg::CH_N: begin
            mode_next     = jtc_pkg::M_LITERAL;
            lit_kind_next = jtc_pkg::LIT_NULL;
            run_len_next  = 8'd1;
          end
          default: begin
            if (jtc_pkg::is_digit(b)) begin
              mode_next    = jtc_pkg::M_INT;
              run_len_next = 8'd1;
              lz_cnt_next  = (b == jtc_pkg::CH_ZERO) ? 8'd1 : 8'd0;
              id_cnt_next  = (b == jtc_pkg::CH_ZERO) ? 8'd0 : 8'd1;
            end else if (!jtc_pkg::is_space(b)) begin
              items[n[1:0]] = '{jtc_pkg::TOK_INVALID, 8'd1};
              n = n + 3'd1;
            end
          end
        endcase
      end
    end
  end

  assign bundle_push  = in_fire && (n != 3'd0);
  assign bundle.count = n;
  assign bundle.items = items;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= jtc_pkg::M_IDLE;
      lit_kind <= jtc_pkg::LIT_TRUE;
      run_len  <= 8'd0;
      lz_cnt   <= 8'd0;
      id_cnt   <= 8'd0;
    end else if (in_fire) begin
      mode     <= mode_next;
      lit_kind <= lit_kind_next;
      run_len  <= run_len_next;
      lz_cnt   <= lz_cnt_next;
      id_cnt   <= id_cnt_next;
    end
  end

endmodule

@@ sv/jtc_queue.sv @@
// Result queue: a small first-in first-out store of bundles between front and back end.
module jtc_queue #(
  parameter int DEPTH = jtc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jtc_pkg::bundle_t  push_data,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output jtc_pkg::bundle_t  head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jtc_pkg::bundle_t store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign head_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

@@ sv/jtc_back.sv @@
// Back end: takes bundles from the queue and hands out their results one per cycle while the output takes them.
module jtc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  jtc_pkg::bundle_t  q_data,
  output logic              pop,
  jtc_out_if.source         token_out
);

  jtc_pkg::bundle_t cur;
  logic             cur_valid;
  logic [1:0]       idx;
  logic             last;
  logic             out_fire;

  assign last     = ({1'b0, idx} == (cur.count - 3'd1));
  assign out_fire = token_out.valid && token_out.ready;
  assign pop      = q_valid && (!cur_valid || (out_fire && last));

  assign token_out.valid        = cur_valid;
  assign token_out.tok_code     = cur.items[idx].tok_code;
  assign token_out.token_length = cur.items[idx].token_length;
  assign token_out.last_of_run  = last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (out_fire) begin
      if (last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule
